// File: design/lis_pkg.sv
package lis_pkg;

    // Fixed widths of the stream fields.
    localparam int unsigned VALUE_OUT_W = 32;
    localparam int unsigned LEN_OUT_W   = 7;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned M_TDATA_W   = 40;

    // Request from the sequencer to the output register.
    typedef struct packed {
        logic push;
        logic last;
    } lis_emit_t;

endpackage

// File: design/lis_mem.sv
module lis_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port; read data is registered.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lis_seq.sv
module lis_seq #(
    parameter int unsigned MAX_ITEMS  = 64,
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned IDX_W      = 6,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned LEN_W      = 7
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Input beats
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VALUE_BITS-1:0]   in_value,
    input  logic                    in_last,
    // Value memory
    output logic                    v_we,
    output logic [IDX_W-1:0]        v_waddr,
    output logic [VALUE_BITS-1:0]   v_wdata,
    output logic [IDX_W-1:0]        v_raddr,
    input  logic [VALUE_BITS-1:0]   v_rdata,
    // Length and successor memory, {length, successor}
    output logic                    l_we,
    output logic [IDX_W-1:0]        l_waddr,
    output logic [LEN_W+IDX_W-1:0]  l_wdata,
    output logic [IDX_W-1:0]        l_raddr,
    input  logic [LEN_W+IDX_W-1:0]  l_rdata,
    // Result side
    input  logic                    out_free,
    output lis_pkg::lis_emit_t      emit,
    output logic [LEN_W-1:0]        emit_len
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DP_HEAD,
        ST_DP_KEY,
        ST_DP_SCAN,
        ST_EM_RD,
        ST_EM_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pidx_reg, pidx_next;
    logic [VALUE_BITS-1:0]   key_reg, key_next;
    logic [LEN_W-1:0]        top_reg, top_next;
    logic [IDX_W-1:0]        succ_reg, succ_next;
    logic [LEN_W-1:0]        best_reg, best_next;
    logic [IDX_W-1:0]        start_reg, start_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;

    logic [LEN_W-1:0]        rd_len;
    logic [IDX_W-1:0]        rd_succ;
    logic [LEN_W-1:0]        len_new;
    logic                    rd_end;

    assign rd_len  = l_rdata[LEN_W+IDX_W-1:IDX_W];
    assign rd_succ = l_rdata[IDX_W-1:0];
    assign len_new = top_reg + LEN_W'(1);
    assign rd_end  = (rd_len <= LEN_W'(1));

    assign emit_len = best_reg;

    // Sequencer: load, backward DP with one compare a cycle, then chain walk.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        succ_next  = succ_reg;
        best_next  = best_reg;
        start_next = start_reg;
        pos_next   = pos_reg;

        in_ready = 1'b0;
        v_we     = 1'b0;
        v_waddr  = count_reg[IDX_W-1:0];
        v_wdata  = in_value;
        v_raddr  = i_reg;
        l_we     = 1'b0;
        l_waddr  = i_reg;
        l_wdata  = {len_new, succ_reg};
        l_raddr  = j_reg[IDX_W-1:0];
        emit     = '0;

        unique case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    v_we       = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (in_last || (count_reg == CNT_W'(MAX_ITEMS - 1))) begin
                        i_next     = count_reg[IDX_W-1:0];
                        best_next  = '0;
                        start_next = '0;
                        state_next = ST_DP_HEAD;
                    end
                end
            end
            ST_DP_HEAD: begin
                // Fetch the value of the position being solved.
                v_raddr    = i_reg;
                j_next     = CNT_W'(i_reg) + CNT_W'(1);
                top_next   = '0;
                succ_next  = '0;
                state_next = ST_DP_KEY;
            end
            ST_DP_KEY: begin
                key_next = v_rdata;
                if (j_reg < count_reg) begin
                    v_raddr   = j_reg[IDX_W-1:0];
                    l_raddr   = j_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                    pidx_next = j_reg[IDX_W-1:0];
                    j_next    = j_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
                state_next = ST_DP_SCAN;
            end
            ST_DP_SCAN: begin
                if (pend_reg) begin
                    // Strictly greater length keeps the earliest successor.
                    if (($signed(v_rdata) > $signed(key_reg)) && (rd_len > top_reg)) begin
                        top_next  = rd_len;
                        succ_next = pidx_reg;
                    end
                    if (j_reg < count_reg) begin
                        v_raddr   = j_reg[IDX_W-1:0];
                        l_raddr   = j_reg[IDX_W-1:0];
                        pidx_next = j_reg[IDX_W-1:0];
                        j_next    = j_reg + CNT_W'(1);
                    end else begin
                        pend_next = 1'b0;
                    end
                end else begin
                    // All successors seen: store the result for this position.
                    l_we = 1'b1;
                    if (len_new >= best_reg) begin
                        best_next  = len_new;
                        start_next = i_reg;
                    end
                    if (i_reg == '0) begin
                        pos_next   = (len_new >= best_reg) ? i_reg : start_reg;
                        state_next = ST_EM_RD;
                    end else begin
                        i_next     = i_reg - IDX_W'(1);
                        state_next = ST_DP_HEAD;
                    end
                end
            end
            ST_EM_RD: begin
                v_raddr    = pos_reg;
                l_raddr    = pos_reg;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                v_raddr = pos_reg;
                l_raddr = pos_reg;
                if (out_free) begin
                    emit.push = 1'b1;
                    emit.last = rd_end;
                    if (rd_end) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        // Fetch the successor straight away.
                        v_raddr  = rd_succ;
                        l_raddr  = rd_succ;
                        pos_next = rd_succ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        pidx_reg  <= pidx_next;
        key_reg   <= key_next;
        top_reg   <= top_next;
        succ_reg  <= succ_next;
        best_reg  <= best_next;
        start_reg <= start_next;
        pos_reg   <= pos_next;
    end

    // The scan pointer never runs past the loaded sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DP_SCAN) |-> (j_reg <= count_reg))
        else $error("DP scan pointer beyond item count");

    // A result is only pushed when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.push |-> (out_free && (state_reg == ST_EM_OUT)))
        else $error("result pushed while output busy");

    // The final beat of a run returns to loading with an empty store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.push && emit.last) |=> ((state_reg == ST_LOAD) && (count_reg == '0)))
        else $error("run did not finish cleanly");

    // The reported length is a real length within the loaded sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_OUT) |-> ((best_reg != '0) && (CNT_W'(best_reg) <= count_reg)))
        else $error("best length out of range");

endmodule

// File: design/longest_increasing_subsequence_unit.sv
// The first result beat of a run is offered once the DP scan, a single compare a cycle, is done.
// Throughput: items load at one beat a cycle; results then leave at one beat a cycle while the sink is ready.
// A new sequence may load while the final result beat still waits in the output register.
// Reset (aresetn low, synchronous) empties the store and the output register; memories
// are not cleared.
module longest_increasing_subsequence_unit #(
    parameter int unsigned MAX_ITEMS  = 64,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: [31:0] item_value; s_tlast: item_last
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lis_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    // m_tdata: [31:0] sub_value, [38:32] sub_length, [39] zero; m_tlast: sub_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lis_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned LEN_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned VO_W  = lis_pkg::VALUE_OUT_W;
    localparam int unsigned LO_W  = lis_pkg::LEN_OUT_W;

    logic [VALUE_BITS+VO_W-1:0]  in_ext;
    logic [VALUE_BITS-1:0]       in_value;
    logic [VALUE_BITS+VO_W-1:0]  out_ext;
    logic [LEN_W+LO_W-1:0]       len_ext;

    logic                        v_we;
    logic [IDX_W-1:0]            v_waddr;
    logic [VALUE_BITS-1:0]       v_wdata;
    logic [IDX_W-1:0]            v_raddr;
    logic [VALUE_BITS-1:0]       v_rdata;
    logic                        l_we;
    logic [IDX_W-1:0]            l_waddr;
    logic [LEN_W+IDX_W-1:0]      l_wdata;
    logic [IDX_W-1:0]            l_raddr;
    logic [LEN_W+IDX_W-1:0]      l_rdata;

    logic                        out_free;
    lis_pkg::lis_emit_t          emit;
    logic [LEN_W-1:0]            emit_len;

    logic                        m_tvalid_reg;
    logic [VO_W-1:0]             value_reg;
    logic [LO_W-1:0]             length_reg;
    logic                        last_reg;

    // Fit the input value to the stored width.
    assign in_ext   = {{VALUE_BITS{1'b0}}, s_tdata[VO_W-1:0]};
    assign in_value = in_ext[VALUE_BITS-1:0];

    lis_mem #(
        .DEPTH  (MAX_ITEMS),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (IDX_W)
    ) u_value_mem (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    lis_mem #(
        .DEPTH  (MAX_ITEMS),
        .WIDTH  (LEN_W + IDX_W),
        .ADDR_W (IDX_W)
    ) u_link_mem (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    lis_seq #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .LEN_W      (LEN_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_value (in_value),
        .in_last  (s_tlast),
        .v_we     (v_we),
        .v_waddr  (v_waddr),
        .v_wdata  (v_wdata),
        .v_raddr  (v_raddr),
        .v_rdata  (v_rdata),
        .l_we     (l_we),
        .l_waddr  (l_waddr),
        .l_wdata  (l_wdata),
        .l_raddr  (l_raddr),
        .l_rdata  (l_rdata),
        .out_free (out_free),
        .emit     (emit),
        .emit_len (emit_len)
    );

    // Fit the stored value and the length to the result fields.
    assign out_ext = {{VO_W{1'b0}}, v_rdata};
    assign len_ext = {{LO_W{1'b0}}, emit_len};

    assign out_free = !m_tvalid_reg || m_tready;

    // Output register: holds one result beat until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (emit.push) begin
            value_reg  <= out_ext[VO_W-1:0];
            length_reg <= len_ext[LO_W-1:0];
            last_reg   <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, length_reg, value_reg};
    assign m_tlast  = last_reg;

endmodule

// File: tb/sv/lis_scoreboard.sv
`timescale 1ns / 100ps

// Watches both stream channels of the subsequence unit, predicts the emitted
// subsequence for every completed input sequence and compares result beats in order.
module lis_scoreboard (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [lis_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lis_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tlast,
    output int unsigned                       mismatch_count,
    output int unsigned                       beats_pending
);

    localparam int unsigned STORE_DEPTH = 64;

    typedef struct packed {
        logic [lis_pkg::VALUE_OUT_W-1:0] value;
        logic [lis_pkg::LEN_OUT_W-1:0]   length;
        logic                            last;
    } sub_beat_t;

    // Expected result beats, oldest first.
    sub_beat_t expected_subseq [$];

    // Our own copy of the loaded sequence.
    logic signed [lis_pkg::VALUE_OUT_W-1:0] seq_vals [STORE_DEPTH];
    int unsigned                            seq_count;

    // Backward DP over the loaded sequence; queues the beats of the best chain.
    task automatic predict_subsequence();
        int unsigned chain_len  [STORE_DEPTH];
        int unsigned chain_next [STORE_DEPTH];
        int unsigned top;
        int unsigned nxt;
        int unsigned best;
        int unsigned start;
        int unsigned pos;
        int unsigned emitted;
        sub_beat_t   beat;

        for (int k = seq_count; k > 0; k--) begin
            top = 0;
            nxt = 0;
            for (int j = k; j < seq_count; j++) begin
                if (seq_vals[j] > seq_vals[k-1] && chain_len[j] > top) begin
                    top = chain_len[j];
                    nxt = j;
                end
            end
            chain_len[k-1]  = top + 1;
            chain_next[k-1] = nxt;
        end

        // The earliest start of greatest length wins.
        best  = 0;
        start = 0;
        for (int i = 0; i < seq_count; i++) begin
            if (chain_len[i] > best) begin
                best  = chain_len[i];
                start = i;
            end
        end

        pos     = start;
        emitted = 0;
        while (emitted < STORE_DEPTH) begin
            beat.value  = seq_vals[pos];
            beat.length = best[lis_pkg::LEN_OUT_W-1:0];
            beat.last   = (chain_len[pos] <= 1);
            expected_subseq.push_back(beat);
            emitted++;
            if (beat.last)
                break;
            pos = chain_next[pos];
        end
        seq_count = 0;
    endtask

    initial begin
        mismatch_count = 0;
        beats_pending  = 0;
        seq_count      = 0;
    end

    always @(posedge aclk) begin
        sub_beat_t want;

        if (!aresetn) begin
            seq_count = 0;
            expected_subseq.delete();
        end else begin
            // Result side first: a beat leaving now belongs to an earlier run.
            if (m_tvalid && m_tready) begin
                if (expected_subseq.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result beat with none expected: %s %h len %0d last %b",
                                 $realtime, "value", m_tdata[31:0], m_tdata[38:32], m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_subseq.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[38:32] !== want.length ||
                        m_tlast !== want.last) begin
                        if (mismatch_count < 10)
                            $display({"%0t: result mismatch: expected value %h len %0d ",
                                      "last %b, got value %h len %0d last %b"},
                                     $realtime, want.value, want.length, want.last,
                                     m_tdata[31:0], m_tdata[38:32], m_tlast);
                        mismatch_count++;
                    end
                end
            end

            // Input side: store the beat; a last beat or a full store starts the solve.
            if (s_tvalid && s_tready) begin
                seq_vals[seq_count] = s_tdata[31:0];
                seq_count++;
                if (s_tlast || seq_count >= STORE_DEPTH)
                    predict_subsequence();
            end
        end
        beats_pending = expected_subseq.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned STORE_DEPTH  = 64;
    localparam int unsigned RANDOM_ITEMS = 350;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lis_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lis_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned mismatch_count;
    int unsigned beats_pending;
    int unsigned random_sent;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    longest_increasing_subsequence_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lis_scoreboard checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Four idling phases: none, sender idle, receiver stalling, both.
    task automatic set_phase(input int unsigned phase);
        case (phase % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
            default: begin src_idle_pct = 32; snk_stall_pct = 32; end
        endcase
    endtask

    // Drives one input beat and returns at the edge where it is taken.
    task automatic send_item(input logic [31:0] value, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_value(input int unsigned mode, input int unsigned idx);
        logic [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(0, 8) - 4;
            2: v = idx * 3 + $urandom_range(0, 6) - 3;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // One random sequence; a full-length one may end on the full store alone.
    task automatic send_random_sequence();
        int unsigned len;
        int unsigned mode;
        logic        final_mark;

        if ($urandom_range(0, 9) == 0)
            len = STORE_DEPTH;
        else if ($urandom_range(0, 5) == 0)
            len = $urandom_range(17, 40);
        else
            len = $urandom_range(1, 16);
        mode       = $urandom_range(0, 3);
        final_mark = (len == STORE_DEPTH) ? 1'($urandom_range(0, 1)) : 1'b1;
        for (int i = 0; i < len; i++) begin
            send_item(pick_value(mode, i), (i == len - 1) ? final_mark : 1'b0);
            random_sent++;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, without idling.
        set_phase(0);
        // Single-element sequences at both extremes.
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b1);
        // Increasing across the sign boundary, so the compare must be signed.
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        // Strictly decreasing: every chain ends at once, the earliest start wins.
        send_item(32'd3, 1'b0);
        send_item(32'd2, 1'b0);
        send_item(32'd1, 1'b1);
        // Equal values never extend a chain.
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b1);
        // Two successors of equal length: the earliest one is followed.
        send_item(32'd1, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(32'd2, 1'b0);
        send_item(32'd4, 1'b1);

        // Random sequences, rotating through the idling phases.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_phase(random_sent / 45);
            send_random_sequence();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge aclk);
        wait (beats_pending == 0);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && beats_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_800_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
